/* hw/rtl/aoc_pkg.sv */
package aoc_pkg;

    localparam int CH_W    = 8;               // one unorm channel
    localparam int NCH     = 3;               // color channels
    localparam int PROD_W  = 2 * CH_W;        // 8x8 product
    localparam int DEN_W   = PROD_W;          // coverage term D, max 65025
    localparam int NUM_W   = 3 * CH_W;        // color numerator, max 255*65025
    localparam int RECIP_W = DEN_W + 1;
    localparam int ALPHA_PROD_W = DEN_W + RECIP_W;
    localparam int RECIP_SHIFT  = 23;

    localparam logic [CH_W-1:0]    UNORM_ONE  = 8'd255;
    localparam logic [DEN_W-1:0]   FULL_COVER = 16'd65025;
    // D / 255 == (D * 0x8081) >> 23 for every 16-bit D
    localparam logic [RECIP_W-1:0] RECIP_255  = 17'h08081;

    typedef struct packed {
        logic [CH_W-1:0] fg_red;
        logic [CH_W-1:0] fg_green;
        logic [CH_W-1:0] fg_blue;
        logic [CH_W-1:0] fg_alpha;
        logic [CH_W-1:0] bg_red;
        logic [CH_W-1:0] bg_green;
        logic [CH_W-1:0] bg_blue;
        logic [CH_W-1:0] bg_alpha;
    } pair_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } pixel_t;

    // carried through the quotient stages
    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] rem;
        logic [NCH-1:0][CH_W-1:0]  quo;
        logic [DEN_W-1:0]          den;
        logic [CH_W-1:0]           alpha;
    } div_t;

endpackage

/* hw/rtl/aoc_stream_if.sv */
interface aoc_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

/* hw/rtl/aoc_front.sv */
module aoc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  aoc_pkg::pair_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output aoc_pkg::div_t  out_data
);
    import aoc_pkg::*;

    typedef struct packed {
        logic [NCH-1:0][PROD_W-1:0] top_c;    // color * top alpha
        logic [NCH-1:0][PROD_W-1:0] bot_c;    // color * bottom alpha
        logic [PROD_W-1:0]          inv_prod; // (1-a_top)(1-a_bot)
        logic [CH_W-1:0]            inv_top;
    } s1_t;

    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]          den;
    } s2_t;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    div_t s3_reg, s3_next;

    logic [CH_W-1:0] top_col [NCH];
    logic [CH_W-1:0] bot_col [NCH];
    logic [ALPHA_PROD_W-1:0] alpha_prod;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;

    // stage 1: 8x8 products
    always_comb
    begin
        top_col[0] = in_data.fg_red;
        top_col[1] = in_data.fg_green;
        top_col[2] = in_data.fg_blue;
        bot_col[0] = in_data.bg_red;
        bot_col[1] = in_data.bg_green;
        bot_col[2] = in_data.bg_blue;
        s1_next.inv_top  = UNORM_ONE - in_data.fg_alpha;
        s1_next.inv_prod = PROD_W'(UNORM_ONE - in_data.fg_alpha)
                         * PROD_W'(UNORM_ONE - in_data.bg_alpha);
        for (int c = 0; c < NCH; c++)
        begin
            s1_next.top_c[c] = PROD_W'(top_col[c]) * PROD_W'(in_data.fg_alpha);
            s1_next.bot_c[c] = PROD_W'(bot_col[c]) * PROD_W'(in_data.bg_alpha);
        end
    end

    // stage 2: numerators and coverage term
    always_comb
    begin
        s2_next.den = FULL_COVER - s1_reg.inv_prod;
        for (int c = 0; c < NCH; c++)
        begin
            s2_next.num[c] = (NUM_W'(s1_reg.top_c[c]) << CH_W)
                           - NUM_W'(s1_reg.top_c[c])
                           + NUM_W'(s1_reg.bot_c[c]) * NUM_W'(s1_reg.inv_top);
        end
    end

    // stage 3: alpha = D / 255 by reciprocal
    always_comb
    begin
        alpha_prod     = ALPHA_PROD_W'(s2_reg.den) * ALPHA_PROD_W'(RECIP_255);
        s3_next.rem    = s2_reg.num;
        s3_next.quo    = '0;
        s3_next.den    = s2_reg.den;
        s3_next.alpha  = alpha_prod[RECIP_SHIFT +: CH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    // D is zero only with both alphas zero, and then every numerator is zero
    a_zero_den_num: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && s2_reg.den == '0 |->
            s2_reg.num[0] == '0 && s2_reg.num[1] == '0 && s2_reg.num[2] == '0)
        else $error("nonzero numerator with zero coverage");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(s1_reg))
        else $error("stage 1 item lost under stall");

endmodule

/* hw/rtl/aoc_div_step.sv */
module aoc_div_step #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  aoc_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output aoc_pkg::div_t out_data
);
    import aoc_pkg::*;

    logic             valid_reg, valid_next;
    div_t             data_reg, data_next;
    logic [NUM_W-1:0] den_sh;
    logic [NUM_W-1:0] den_sh_q;
    logic [NUM_W:0]   trial [NCH];

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // restoring division, one quotient bit per stage
    always_comb
    begin
        den_sh    = NUM_W'(in_data.den) << BIT;
        data_next = in_data;
        for (int c = 0; c < NCH; c++)
        begin
            trial[c] = {1'b0, in_data.rem[c]} - {1'b0, den_sh};
            if (!trial[c][NUM_W])
            begin
                data_next.rem[c]      = trial[c][NUM_W-1:0];
                data_next.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign den_sh_q  = NUM_W'(data_reg.den) << BIT;

    // quotient fits in 8 bits, so the partial remainder stays below D << BIT
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.den != '0 |->
            data_reg.rem[0] < den_sh_q && data_reg.rem[1] < den_sh_q
            && data_reg.rem[2] < den_sh_q)
        else $error("partial remainder out of range");

endmodule

/* hw/rtl/alpha_over_compositor.sv */
// Straight-alpha "over" compositor: one foreground/background pixel pair in,
// one composited pixel out, 8-bit unorm channels, all results truncated.
// Accepts one item per clock while the output is not stalled; an item passes
// through 3 multiply stages (products, numerators and coverage, alpha by
// reciprocal), 8 divider stages that each resolve one quotient bit for all
// three colors, and the output register. A fully transparent result (both
// alphas zero) gives zero color. Stalls back up through the stages; bubbles
// are squeezed out, so input stays open under a stall until all stages fill.
module alpha_over_compositor (
    input  logic        clk,
    input  logic        rst_n,
    aoc_stream_if.sink   pixel_pair,
    aoc_stream_if.source pixel
);
    import aoc_pkg::*;

    logic   div_v [CH_W+1];
    logic   div_r [CH_W+1];
    div_t   div_d [CH_W+1];

    logic   out_v_reg, out_v_next;
    pixel_t out_reg, out_next;
    logic   out_rdy;
    div_t   last;

    aoc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_pair.valid),
        .in_ready  (pixel_pair.ready),
        .in_data   (pixel_pair.data),
        .out_valid (div_v[0]),
        .out_ready (div_r[0]),
        .out_data  (div_d[0])
    );

    for (genvar k = 0; k < CH_W; k++)
    begin : g_div
        aoc_div_step #(
            .BIT (CH_W - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_v[k]),
            .in_ready  (div_r[k]),
            .in_data   (div_d[k]),
            .out_valid (div_v[k+1]),
            .out_ready (div_r[k+1]),
            .out_data  (div_d[k+1])
        );
    end

    assign last          = div_d[CH_W];
    assign out_rdy       = !out_v_reg || pixel.ready;
    assign div_r[CH_W]   = out_rdy;
    assign out_v_next    = out_rdy ? div_v[CH_W] : out_v_reg;

    always_comb
    begin
        out_next.out_alpha = last.alpha;
        if (last.den == '0)
        begin
            out_next.out_red   = '0;
            out_next.out_green = '0;
            out_next.out_blue  = '0;
        end
        else
        begin
            out_next.out_red   = last.quo[0];
            out_next.out_green = last.quo[1];
            out_next.out_blue  = last.quo[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_v[CH_W])
        begin
            out_reg <= out_next;
        end
    end

    assign pixel.valid = out_v_reg;
    assign pixel.data  = out_reg;

    a_transparent_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        div_v[CH_W] && last.den == '0 |-> last.alpha == '0)
        else $error("zero coverage with nonzero alpha");

endmodule

/* dv/tb_alpha_over_compositor.sv */
module tb_alpha_over_compositor;
    timeunit 1ns;
    timeprecision 1ps;

    import aoc_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    aoc_stream_if #(.data_t(pair_t))  pair_if ();
    aoc_stream_if #(.data_t(pixel_t)) pix_if ();

    alpha_over_compositor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_pair (pair_if.sink),
        .pixel      (pix_if.source)
    );

    always #5 clk = ~clk;

    pixel_t      expected_pixels[$];
    int unsigned errors    = 0;
    bit          idle_mode = 1'b1;
    int unsigned sink_hold = 0;

    // one color channel of the over operator, truncated
    function automatic logic [CH_W-1:0] mix_color(
        input int unsigned s_c,
        input int unsigned d_c,
        input int unsigned s_a,
        input int unsigned d_a,
        input int unsigned cov_term
    );
        int unsigned num;
        int unsigned quo;
        if (cov_term == 0)
            return '0;
        num = s_c * s_a * UNORM_ONE + d_c * d_a * (UNORM_ONE - s_a);
        quo = num / cov_term;
        return (quo > UNORM_ONE) ? UNORM_ONE : quo[CH_W-1:0];
    endfunction

    function automatic pixel_t over_blend(input pair_t pr);
        logic [CH_W-1:0] sr, sg, sb, sa, dr, dg, db, da;
        int unsigned     cov_term;
        pixel_t          px;
        {sr, sg, sb, sa, dr, dg, db, da} = pr;
        cov_term = int'(FULL_COVER)
                   - (int'(UNORM_ONE) - int'(sa)) * (int'(UNORM_ONE) - int'(da));
        px.out_red   = mix_color(sr, dr, sa, da, cov_term);
        px.out_green = mix_color(sg, dg, sa, da, cov_term);
        px.out_blue  = mix_color(sb, db, sa, da, cov_term);
        px.out_alpha = 8'(cov_term / UNORM_ONE);
        return px;
    endfunction

    function automatic pair_t pack_pair(
        input logic [7:0] sr, sg, sb, sa,
        input logic [7:0] dr, dg, db, da
    );
        return {sr, sg, sb, sa, dr, dg, db, da};
    endfunction

    // alphas lean toward the edges where the division gets interesting
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(4, 1));
            3:       return 8'($urandom_range(254, 251));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pair_t rand_pair();
        return pack_pair(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), pick_alpha(),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), pick_alpha());
    endfunction

    task automatic send_pair(input pair_t pr);
        while (idle_mode && $urandom_range(99) < 12)
        begin
            pair_if.valid <= 1'b0;
            @(posedge clk);
        end
        pair_if.valid <= 1'b1;
        pair_if.data  <= pr;
        do @(posedge clk); while (!pair_if.ready);
        expected_pixels.push_back(over_blend(pr));
    endtask

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // result side: check, then pick ready for the next cycle
    initial
    begin : pixel_sink
        pixel_t want;
        pix_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_if.valid && pix_if.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result item %h", pix_if.data);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("out_red",   want.out_red,   pix_if.data.out_red);
                    check_channel("out_green", want.out_green, pix_if.data.out_green);
                    check_channel("out_blue",  want.out_blue,  pix_if.data.out_blue);
                    check_channel("out_alpha", want.out_alpha, pix_if.data.out_alpha);
                end
            end
            if (sink_hold > 0)
            begin
                pix_if.ready <= 1'b0;
                sink_hold--;
            end
            else
                pix_if.ready <= !(idle_mode && $urandom_range(99) < 12);
        end
    end

    task automatic test_corners();
        send_pair(pack_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
        // both alphas zero: fully transparent, color forced to zero
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0));
        send_pair(pack_pair(8'hAA,  8'h55,  8'hFF,  8'd0,   8'h55,  8'hAA,  8'h01,  8'd0));
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(pack_pair(8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd255, 8'd7,   8'd0));
        send_pair(pack_pair(8'd255, 8'd0,   8'd128, 8'd0,   8'd0,   8'd255, 8'd7,   8'd255));
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd200, 8'd100, 8'd50,  8'd1));
        send_pair(pack_pair(8'd200, 8'd100, 8'd50,  8'd1,   8'd255, 8'd255, 8'd255, 8'd0));
        send_pair(pack_pair(8'd255, 8'd0,   8'd255, 8'd1,   8'd0,   8'd255, 8'd0,   8'd1));
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd254));
        send_pair(pack_pair(8'd0,   8'd0,   8'd0,   8'd254, 8'd255, 8'd255, 8'd255, 8'd1));
        send_pair(pack_pair(8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255));
        send_pair(pack_pair(8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'h55,  8'h55,  8'h55,  8'h55));
        send_pair(pack_pair(8'h55,  8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA,  8'hAA));
        send_pair(pack_pair(8'd128, 8'd64,  8'd32,  8'd128, 8'd16,  8'd8,   8'd4,   8'd128));
        send_pair(pack_pair(8'd1,   8'd2,   8'd3,   8'd1,   8'd254, 8'd253, 8'd252, 8'd255));
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd127, 8'd255, 8'd255, 8'd255, 8'd128));
        send_pair(pack_pair(8'd0,   8'd0,   8'd0,   8'd128, 8'd255, 8'd255, 8'd255, 8'd254));
        send_pair(pack_pair(8'd255, 8'd255, 8'd255, 8'd1,   8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(pack_pair(8'd17,  8'd34,  8'd68,  8'd0,   8'd136, 8'd0,   8'd255, 8'd0));
    endtask

    task automatic test_random_stream();
        // idling on both sides first, then a long run at full rate
        for (int i = 0; i < 1020; i++)
        begin
            idle_mode = (i < 620);
            send_pair(rand_pair());
        end
        idle_mode = 1'b1;
    endtask

    task automatic test_output_stall();
        // sink holds off long enough for the pipeline to fill and push back
        sink_hold = 300;
        for (int i = 0; i < 60; i++)
            send_pair(rand_pair());
    endtask

    initial
    begin : run_tests
        rst_n         <= 1'b0;
        pair_if.valid <= 1'b0;
        pair_if.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_output_stall();
        test_random_stream();

        pair_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (errors == 0)
            $display("tb_alpha_over_compositor OK");
        else
            $display("tb_alpha_over_compositor NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_alpha_over_compositor NOT OK");
        $finish;
    end

endmodule
